// ===== design/assert_macros.svh =====
// assertion helpers shared by the bank controller modules
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CBC_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// consequence must hold in the cycle after the antecedent
`define CBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/cbc_pkg.sv =====
// shared types and constants of the cartridge bank controller
// no dependencies
`default_nettype none

package cbc_pkg;

	// field widths
	localparam int ADDR_W       = 16;
	localparam int DATA_W       = 8;
	localparam int MAP_W        = 22;
	localparam int BANK_W       = 8;
	localparam int RAM_BANK_W   = 2;
	localparam int ROM_BANK_BITS_DEF = 8;

	// data nibble that turns external RAM on
	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

	// controller types
	typedef enum logic [1:0] {
		CART_ROM  = 2'd0,
		CART_MBC1 = 2'd1,
		CART_MBC2 = 2'd2,
		CART_MBC3 = 2'd3
	} cart_t;

	// memory select codes
	typedef enum logic [1:0] {
		SEL_NONE = 2'd0,
		SEL_ROM  = 2'd1,
		SEL_RAM  = 2'd2
	} mem_sel_t;

	// register regions below 0x8000, address bits 14:13
	typedef enum logic [1:0] {
		REG_RAM_EN   = 2'd0,
		REG_ROM_LO   = 2'd1,
		REG_ROM_HI   = 2'd2,
		REG_MODE     = 2'd3
	} region_t;

	// one bus access
	typedef struct packed {
		logic              write;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} access_t;

	// one translated result
	typedef struct packed {
		mem_sel_t              sel;
		logic [MAP_W-1:0]      mapped;
		logic [BANK_W-1:0]     rom_bank;
		logic [RAM_BANK_W-1:0] ram_bank;
		logic                  ram_en;
		logic                  err;
	} result_t;

endpackage

`default_nettype wire

// ===== design/cartridge_bank_controller.sv =====
// Cartridge bank controller for plain ROM, MBC1, MBC2 and MBC3 carts. Each item is one CPU
// bus access; writes below 0x8000 update the bank registers, reads of ROM or external RAM
// space come back with the physical address. An item passes the input register, then the result
// register; one item is accepted every cycle while in_stall is low. Bank registers update as an
// item leaves the input register, so a bank write is seen by the very next access. The user
// must write cart_type via cfg_we/cfg_wdata while the block is idle; it is not enforced.
// top level; depends on cbc_pkg, cbc_bank_unit and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module cartridge_bank_controller #(
	parameter int ROM_BANK_BITS = cbc_pkg::ROM_BANK_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_we,
	input  wire logic [1:0]                        cfg_wdata,
	// access channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              operation,
	input  wire logic [cbc_pkg::ADDR_W-1:0]        address,
	input  wire logic [cbc_pkg::DATA_W-1:0]        write_data,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [1:0]                             mem_select,
	output logic [cbc_pkg::MAP_W-1:0]              mapped_address,
	output logic [cbc_pkg::BANK_W-1:0]             rom_bank_now,
	output logic [cbc_pkg::RAM_BANK_W-1:0]         ram_bank_now,
	output logic                                   ram_enabled,
	output logic                                   error
);

	logic [1:0]        cart_type_q;
	logic              valid_s1, valid_s2;
	cbc_pkg::access_t  acc_s1;
	cbc_pkg::result_t  res, res_s2;
	logic              adv_s1, take_in;

	// cart type register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cart_type_q <= cbc_pkg::CART_ROM;
		else if (cfg_we)
			cart_type_q <= cfg_wdata;
	end

	// flow control
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign take_in  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take_in || adv_s1)
			valid_s1 <= take_in;
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			acc_s1.write <= operation;
			acc_s1.addr  <= address;
			acc_s1.data  <= write_data;
		end
	end

	cbc_bank_unit #(
		.ROM_BANK_BITS(ROM_BANK_BITS)
	) u_bank (
		.clk      (clk),
		.arst_n   (arst_n),
		.cart_type(cbc_pkg::cart_t'(cart_type_q)),
		.acc      (acc_s1),
		.fire     (adv_s1),
		.res      (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv_s1 || !out_stall)
			valid_s2 <= adv_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			res_s2 <= res;
	end

	assign out_valid      = valid_s2;
	assign mem_select     = res_s2.sel;
	assign mapped_address = res_s2.mapped;
	assign rom_bank_now   = res_s2.rom_bank;
	assign ram_bank_now   = res_s2.ram_bank;
	assign ram_enabled    = res_s2.ram_en;
	assign error          = res_s2.err;

	`CBC_ASSERT_NEXT(a_item_reaches_output, adv_s1, valid_s2, "item lost between stages")
	`CBC_ASSERT_ALWAYS(a_stall_only_when_full, !in_stall || (valid_s1 && valid_s2),
		"input stalled with room in the pipe")

endmodule

`default_nettype wire

// ===== design/cbc_bank_unit.sv =====
// bank registers, register write decode and address translation
// depends on cbc_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module cbc_bank_unit #(
	parameter int ROM_BANK_BITS = cbc_pkg::ROM_BANK_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cbc_pkg::cart_t  cart_type,
	input  wire cbc_pkg::access_t acc,
	input  wire logic            fire,
	output cbc_pkg::result_t     res
);

	localparam logic [ROM_BANK_BITS-1:0] ROM_BANK_ONE = ROM_BANK_BITS'(1);

	logic [ROM_BANK_BITS-1:0]          rom_bank_q, rom_bank_d;
	logic [cbc_pkg::RAM_BANK_W-1:0]    ram_bank_q, ram_bank_d;
	logic                              ram_enable_q, ram_enable_d;
	logic                              ram_mode_q, ram_mode_d;
	logic [cbc_pkg::BANK_W-1:0]        rom_ext, rom_cand;
	logic [ROM_BANK_BITS-1:0]          rom_masked;
	logic                              reg_write, enable_hit, err;
	cbc_pkg::region_t                  region;

	assign rom_ext    = cbc_pkg::BANK_W'(rom_bank_q);
	assign region     = cbc_pkg::region_t'(acc.addr[14:13]);
	assign reg_write  = acc.write && !acc.addr[15];
	assign enable_hit = (acc.data[3:0] == cbc_pkg::RAM_ENABLE_KEY);

	// register write decode
	always_comb begin
		rom_cand     = rom_ext;
		ram_bank_d   = ram_bank_q;
		ram_enable_d = ram_enable_q;
		ram_mode_d   = ram_mode_q;
		err          = 1'b0;
		if (reg_write && cart_type != cbc_pkg::CART_ROM) begin
			case (region)
				cbc_pkg::REG_RAM_EN: begin
					if (cart_type != cbc_pkg::CART_MBC2 || !acc.addr[12])
						ram_enable_d = enable_hit;
				end
				cbc_pkg::REG_ROM_LO: begin
					case (cart_type)
						cbc_pkg::CART_MBC1: rom_cand = {rom_ext[7:5], acc.data[4:0]};
						cbc_pkg::CART_MBC2: begin
							if (acc.addr[15:8] == 8'h21)
								rom_cand = {4'b0000, acc.data[3:0]};
						end
						default: rom_cand = {rom_ext[7], acc.data[6:0]};
					endcase
				end
				cbc_pkg::REG_ROM_HI: begin
					if (cart_type == cbc_pkg::CART_MBC1) begin
						if (!ram_mode_q)
							rom_cand = {1'b0, acc.data[1:0], rom_ext[4:0]};
						else
							ram_bank_d = acc.data[1:0];
					end else if (cart_type == cbc_pkg::CART_MBC3) begin
						err = 1'b1;
					end
				end
				default: begin
					if (cart_type == cbc_pkg::CART_MBC1) begin
						ram_mode_d = acc.data[0];
						if (!acc.data[0])
							ram_bank_d = '0;
					end else if (cart_type == cbc_pkg::CART_MBC3) begin
						err = 1'b1;
					end
				end
			endcase
		end
	end

	// mask to the implemented bank bits, bank zero maps to one
	assign rom_masked = rom_cand[ROM_BANK_BITS-1:0];
	assign rom_bank_d = (rom_masked == '0) ? ROM_BANK_ONE : rom_masked;

	// bank state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q   <= ROM_BANK_ONE;
			ram_bank_q   <= '0;
			ram_enable_q <= 1'b0;
			ram_mode_q   <= 1'b0;
		end else if (fire) begin
			rom_bank_q   <= rom_bank_d;
			ram_bank_q   <= ram_bank_d;
			ram_enable_q <= ram_enable_d;
			ram_mode_q   <= ram_mode_d;
		end
	end

	// address translation, reads leave the banks as they are
	always_comb begin
		res.sel    = cbc_pkg::SEL_NONE;
		res.mapped = '0;
		if (!acc.addr[15]) begin
			if (!acc.write) begin
				res.sel = cbc_pkg::SEL_ROM;
				if (!acc.addr[14])
					res.mapped = cbc_pkg::MAP_W'(acc.addr);
				else
					res.mapped = {rom_ext, acc.addr[13:0]};
			end
		end else if (acc.addr[14:13] == 2'b01) begin
			res.sel    = cbc_pkg::SEL_RAM;
			res.mapped = cbc_pkg::MAP_W'({ram_bank_q, acc.addr[12:0]});
		end
		res.rom_bank = cbc_pkg::BANK_W'(rom_bank_d);
		res.ram_bank = ram_bank_d;
		res.ram_en   = ram_enable_d;
		res.err      = err;
	end

	`CBC_ASSERT_ALWAYS(a_rom_bank_nonzero, rom_bank_q != '0, "rom bank register holds zero")
	`CBC_ASSERT_NEXT(a_plain_rom_static, fire && cart_type == cbc_pkg::CART_ROM,
		rom_bank_q == $past(rom_bank_q) && ram_enable_q == $past(ram_enable_q), "plain rom changed state")
	`CBC_ASSERT_NEXT(a_rom_mode_clears_ram_bank,
		fire && reg_write && cart_type == cbc_pkg::CART_MBC1 && region == cbc_pkg::REG_MODE && !acc.data[0],
		ram_bank_q == '0 && !ram_mode_q, "rom banking mode left a ram bank set")

endmodule

`default_nettype wire
